// File: hdl/sitd_pkg.sv
// Shared constants and sizing functions for the signed integer to decimal text unit.
package sitd_pkg;

    localparam int DEF_VALUE_WIDTH = 32;
    localparam int DABBLE_STEPS    = 4;
    localparam int CHAR_WIDTH      = 8;

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;

    // Decimal digits that cover a magnitude of up to 2^(w-1) (31/100 > log10 2).
    function automatic int f_digits(input int w);
        return (w * 31) / 100 + 1;
    endfunction

    // Binary width padded up to whole dabble stages.
    function automatic int f_bin_bits(input int w);
        return ((w + DABBLE_STEPS - 1) / DABBLE_STEPS) * DABBLE_STEPS;
    endfunction

    function automatic int f_stages(input int w);
        return (w + DABBLE_STEPS - 1) / DABBLE_STEPS;
    endfunction

endpackage

// File: hdl/sitd_abs.sv
// Input stage: registers the sign and the unsigned magnitude of the incoming value.
module sitd_abs
    import sitd_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int DATA_WIDTH  = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [DATA_WIDTH-1:0]  i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [VALUE_WIDTH-1:0] o_mag,
    output logic                   o_neg
);

    logic                   r_valid;
    logic                   r_neg;
    logic [VALUE_WIDTH-1:0] r_mag;
    logic [VALUE_WIDTH-1:0] w_value;
    logic [VALUE_WIDTH-1:0] n_mag;

    assign w_value = i_data[VALUE_WIDTH-1:0];
    assign n_mag   = w_value[VALUE_WIDTH-1] ? (~w_value + 1'b1) : w_value;
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mag <= n_mag;
            r_neg <= w_value[VALUE_WIDTH-1];
        end
    end

    assign o_valid = r_valid;
    assign o_mag   = r_mag;
    assign o_neg   = r_neg;

endmodule

// File: hdl/sitd_dabble.sv
// One double-dabble pipeline stage: shifts a few magnitude bits into the BCD digits.
module sitd_dabble
    import sitd_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [4*f_digits(VALUE_WIDTH)-1:0]   i_bcd,
    input  logic [f_bin_bits(VALUE_WIDTH)-1:0]   i_bin,
    input  logic                                 i_neg,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [4*f_digits(VALUE_WIDTH)-1:0]   o_bcd,
    output logic [f_bin_bits(VALUE_WIDTH)-1:0]   o_bin,
    output logic                                 o_neg
);

    localparam int ND = f_digits(VALUE_WIDTH);
    localparam int BW = 4 * ND;
    localparam int NB = f_bin_bits(VALUE_WIDTH);

    logic          r_valid;
    logic          r_neg;
    logic [BW-1:0] r_bcd;
    logic [NB-1:0] r_bin;
    logic [BW-1:0] n_bcd;
    logic [NB-1:0] n_bin;

    always_comb begin
        n_bcd = i_bcd;
        n_bin = i_bin;
        for (int s = 0; s < DABBLE_STEPS; s++) begin
            // add 3 to every digit of 5 or more, then shift one bit in
            for (int d = 0; d < ND; d++) begin
                if (n_bcd[d*4 +: 4] >= 4'd5) begin
                    n_bcd[d*4 +: 4] = n_bcd[d*4 +: 4] + 4'd3;
                end
            end
            n_bcd = {n_bcd[BW-2:0], n_bin[NB-1]};
            n_bin = {n_bin[NB-2:0], 1'b0};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bcd <= n_bcd;
            r_bin <= n_bin;
            r_neg <= i_neg;
        end
    end

    assign o_valid = r_valid;
    assign o_bcd   = r_bcd;
    assign o_bin   = r_bin;
    assign o_neg   = r_neg;

endmodule

// File: hdl/sitd_ser.sv
// Character serializer: finds the leading digit and emits sign and digits one beat each.
module sitd_ser
    import sitd_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [4*f_digits(VALUE_WIDTH)-1:0] i_bcd,
    input  logic                               i_neg,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [CHAR_WIDTH-1:0]              o_char,
    output logic                               o_last
);

    localparam int ND = f_digits(VALUE_WIDTH);
    localparam int BW = 4 * ND;
    localparam int IW = $clog2(ND);

    logic                  r_busy;
    logic                  r_neg_pend;
    logic [IW-1:0]         r_idx;
    logic [BW-1:0]         r_bcd;
    logic                  r_ov;
    logic [CHAR_WIDTH-1:0] r_char;
    logic                  r_last;

    logic          w_adv;
    logic          w_final;
    logic          w_load;
    logic [IW-1:0] w_lead;
    logic [3:0]    w_digit;

    // highest nonzero digit, or the lowest digit for zero
    always_comb begin
        w_lead = '0;
        for (int i = 0; i < ND; i++) begin
            if (i_bcd[i*4 +: 4] != 4'd0) begin
                w_lead = IW'(i);
            end
        end
    end

    assign w_digit = r_bcd[r_idx*4 +: 4];
    assign w_adv   = !r_ov || i_ready;
    assign w_final = r_busy && !r_neg_pend && (r_idx == '0);
    assign o_ready = !r_busy || (w_adv && w_final);
    assign w_load  = o_ready && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (w_adv) begin
                r_ov <= r_busy;
            end
            if (w_load) begin
                r_busy <= 1'b1;
            end else if (w_adv && w_final) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_busy) begin
            if (r_neg_pend) begin
                r_char     <= CHAR_MINUS;
                r_last     <= 1'b0;
                r_neg_pend <= 1'b0;
            end else begin
                r_char <= CHAR_ZERO + {4'd0, w_digit};
                r_last <= (r_idx == '0);
                if (r_idx != '0) begin
                    r_idx <= r_idx - 1'b1;
                end
            end
        end
        if (w_load) begin
            r_bcd      <= i_bcd;
            r_neg_pend <= i_neg;
            r_idx      <= w_lead;
        end
    end

    assign o_valid = r_ov;
    assign o_char  = r_char;
    assign o_last  = r_last;

endmodule

// File: hdl/signed_int_to_decimal_ascii_unit.sv
// Top level of the signed integer to decimal ASCII text converter.
//
// Each input beat carries one two's-complement integer; the unit returns its decimal
// text as one output beat per character, most significant first, a leading '-' for
// negative values, no leading zeros, '0' for zero, tlast on the last character.
// Characters leave at one per cycle while the receiver keeps tready high; a number's
// text has 1 to 11 characters at 32 bits (up to 20 at 64 bits). The conversion is a
// double-dabble pipeline of ceil(VALUE_WIDTH/4) stages behind a sign/magnitude stage,
// and the first character is registered in the serializer after the number has passed
// the sign/magnitude register and every dabble stage; later numbers queue in the
// pipeline behind the character serializer, which sets the sustained rate.
module signed_int_to_decimal_ascii_unit
    import sitd_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    input  logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] i_s_axis_tdata,  // [VW-1:0] value
    output logic                                     o_m_axis_tvalid,
    input  logic                                     i_m_axis_tready,
    output logic [CHAR_WIDTH-1:0]                    o_m_axis_tdata,  // [7:0] text_char
    output logic                                     o_m_axis_tlast   // final_char
);

    localparam int DW   = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int ND   = f_digits(VALUE_WIDTH);
    localparam int BW   = 4 * ND;
    localparam int NB   = f_bin_bits(VALUE_WIDTH);
    localparam int NSTG = f_stages(VALUE_WIDTH);

    logic                   w_abs_valid;
    logic [VALUE_WIDTH-1:0] w_abs_mag;
    logic [NSTG:0]          w_valid;
    logic [NSTG:0]          w_ready;
    logic [NSTG:0]          w_neg;
    logic [BW-1:0]          w_bcd [NSTG+1];
    logic [NB-1:0]          w_bin [NSTG+1];

    sitd_abs #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DATA_WIDTH  (DW)
    ) u_abs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .o_valid (w_abs_valid),
        .i_ready (w_ready[0]),
        .o_mag   (w_abs_mag),
        .o_neg   (w_neg[0])
    );

    assign w_valid[0] = w_abs_valid;
    assign w_bcd[0]   = '0;
    assign w_bin[0]   = NB'(w_abs_mag);

    for (genvar g = 0; g < NSTG; g++) begin : g_dabble
        sitd_dabble #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_bcd   (w_bcd[g]),
            .i_bin   (w_bin[g]),
            .i_neg   (w_neg[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_bcd   (w_bcd[g+1]),
            .o_bin   (w_bin[g+1]),
            .o_neg   (w_neg[g+1])
        );
    end

    sitd_ser #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[NSTG]),
        .o_ready (w_ready[NSTG]),
        .i_bcd   (w_bcd[NSTG]),
        .i_neg   (w_neg[NSTG]),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_char  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

endmodule

// File: tb/tb_signed_int_to_decimal_ascii_unit.sv
// Testbench for the signed integer to decimal ASCII unit: directed table, random values, flow control.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii_unit;
    import sitd_pkg::*;

    localparam int VALUE_WIDTH  = 32;
    localparam int N_DIRECTED   = 20;
    localparam int N_PER_PHASE  = 62;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] ch;
        logic                  last;
    } t_text_beat;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [VALUE_WIDTH-1:0] i_s_axis_tdata;   // [31:0] value
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [CHAR_WIDTH-1:0]  o_m_axis_tdata;   // [7:0] text_char
    logic                   o_m_axis_tlast;   // final_char

    t_text_beat pending_chars[$];
    int         idle_pct;
    int         stall_pct;
    int         n_errors;
    int         n_numbers;
    int         n_chars;
    int         quiet_cycles;

    // Directed rows: an empty text means the row is checked by the predictor only.
    logic [VALUE_WIDTH-1:0] dir_value [N_DIRECTED] = '{
        32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, -32'sd9, 32'd100,
        32'h7FFFFFFF, 32'h80000000, 32'h80000001, 32'd1000000000, -32'sd1000000000,
        32'd999999999, 32'd12345, -32'sd987654321, 32'hAAAAAAAA, 32'h55555555,
        32'd2000000000, 32'd1999999999
    };
    string dir_text [N_DIRECTED] = '{
        "0", "1", "-1", "9", "10", "-10", "-9", "100",
        "2147483647", "-2147483648", "-2147483647", "1000000000", "-1000000000",
        "999999999", "", "", "", "", "", ""
    };

    signed_int_to_decimal_ascii_unit #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Queue the characters of one number, sign first, digits most significant first.
    function automatic void predict_text(input logic [VALUE_WIDTH-1:0] value);
        logic [VALUE_WIDTH-1:0] magnitude;
        logic [CHAR_WIDTH-1:0]  chars[$];
        logic                   negative;
        negative  = value[VALUE_WIDTH-1];
        magnitude = negative ? (~value + 1'b1) : value;
        do begin
            chars.push_front(CHAR_ZERO + CHAR_WIDTH'(magnitude % 10));
            magnitude = magnitude / 10;
        end while (magnitude != 0);
        if (negative)
            chars.push_front(CHAR_MINUS);
        foreach (chars[k])
            pending_chars.push_back('{ch: chars[k], last: (k == chars.size() - 1)});
    endfunction

    function automatic void queue_typed_text(input string text);
        for (int k = 0; k < text.len(); k++)
            pending_chars.push_back('{ch: text[k], last: (k == text.len() - 1)});
    endfunction

    // Mix full-range values with values of every digit count and the boundaries.
    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        logic [VALUE_WIDTH-1:0] power;
        logic [VALUE_WIDTH-1:0] value;
        int                     kind;
        int                     ndig;
        kind  = $urandom_range(0, 9);
        ndig  = $urandom_range(1, 9);
        power = 1;
        repeat (ndig) power = power * 10;
        case (kind)
            0, 1, 2, 3: value = $urandom;
            4, 5, 6: value = $urandom % power;
            7: value = power + $urandom_range(0, 2) - 1;
            8: value = $urandom_range(0, 1) ? 32'h80000000 + $urandom_range(0, 3)
                                           : 32'h7FFFFFFF - $urandom_range(0, 3);
            default: value = $urandom_range(0, 20);
        endcase
        if (kind != 8 && $urandom_range(0, 1))
            value = ~value + 1'b1;
        return value;
    endfunction

    // Call at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_value(input logic [VALUE_WIDTH-1:0] value, input string text);
        if ($urandom_range(0, 99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(0, 99) < idle_pct) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (text.len() != 0)
            queue_typed_text(text);
        else
            predict_text(value);
        n_numbers++;
        @(negedge i_clk);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_value(pick_value(), "");
    endtask

    always @(negedge i_clk)
        if (i_rst_n)
            i_m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            n_chars++;
            if (pending_chars.size() == 0) begin
                $error("unexpected beat: text_char %h final_char %b",
                       o_m_axis_tdata, o_m_axis_tlast);
                n_errors++;
            end else begin
                t_text_beat want;
                want = pending_chars.pop_front();
                if (o_m_axis_tdata !== want.ch) begin
                    $error("text_char: expected %h, got %h", want.ch, o_m_axis_tdata);
                    n_errors++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $error("final_char: expected %b, got %b", want.last, o_m_axis_tlast);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: count cycles in which neither side moves a beat.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        idle_pct        = 0;
        stall_pct       = 0;
        n_errors        = 0;
        n_numbers       = 0;
        n_chars         = 0;
        quiet_cycles    = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++)
            send_value(dir_value[r], dir_text[r]);
        run_random(N_PER_PHASE);

        idle_pct  = 68;
        run_random(N_PER_PHASE);

        idle_pct  = 0;
        stall_pct = 68;
        run_random(N_PER_PHASE);

        idle_pct  = 30;
        stall_pct = 30;
        run_random(N_PER_PHASE);

        i_s_axis_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Converted %0d numbers to %0d characters: directed extremes, random values",
                 n_numbers, n_chars);
        $display("of every digit count, and sender idling and receiver stalls in four phases.");
        if (n_errors == 0 && pending_chars.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
